// File: hdl/gbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared widths, constants and types for the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_BOXES_DEF = 128;

    localparam int COORD_W = 16;   // signed Q11.4 edge
    localparam int SIZE_W  = 15;   // unsigned Q11.4 extent
    localparam int THR_W   = 11;   // Q1.10 IoU limit
    localparam int RANK_W  = 7;
    localparam int TOTAL_W = 8;
    localparam int POS_W   = 8;

    localparam int AREA_W  = 2 * SIZE_W;           // 30 bits
    localparam int UNION_W = AREA_W + 1;           // 31 bits
    localparam int PROD_W  = THR_W + UNION_W;      // 42 bits
    localparam int FRAC_W  = 10;                   // inter * 1024

    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(410);
    localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
    } t_box;

    typedef struct packed {
        logic busy;   // compares still in flight
        logic hit;    // a kept box suppresses the current one
    } t_pipe_status;

endpackage

// File: hdl/gbs_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs channel interfaces
// Valid/ready channels for box items, result items and threshold writes.
// ----------------------------------------------------------------------------
interface gbs_box_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 first_box;
    logic signed [gbs_pkg::COORD_W-1:0]   box_left;
    logic signed [gbs_pkg::COORD_W-1:0]   box_top;
    logic [gbs_pkg::SIZE_W-1:0]           box_width;
    logic [gbs_pkg::SIZE_W-1:0]           box_height;

    modport source (output valid, first_box, box_left, box_top, box_width, box_height,
                    input ready);
    modport sink   (input valid, first_box, box_left, box_top, box_width, box_height,
                    output ready);
endinterface

interface gbs_res_if;
    logic                         valid;
    logic                         ready;
    logic                         keep;
    logic [gbs_pkg::RANK_W-1:0]   box_rank;
    logic [gbs_pkg::TOTAL_W-1:0]  kept_total;
    logic                         overflow;

    modport source (output valid, keep, box_rank, kept_total, overflow, input ready);
    modport sink   (input valid, keep, box_rank, kept_total, overflow, output ready);
endinterface

interface gbs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::THR_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/gbs_box_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_box_store
// Kept-box memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbs_box_store #(
    parameter int DEPTH = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  gbs_pkg::t_box             i_wr_data,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output gbs_pkg::t_box             o_rd_data
);
    import gbs_pkg::*;

    t_box r_mem [DEPTH];
    t_box r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/gbs_iou_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_iou_pipe
// Pipelined overlap test of the current box against one kept box per cycle.
// ----------------------------------------------------------------------------
module gbs_iou_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_issue,     // read issued this cycle
    input  gbs_pkg::t_box              i_cur,
    input  gbs_pkg::t_box              i_kept,      // store data, in the cycle after issue
    input  logic [gbs_pkg::THR_W-1:0]  i_thr,
    output gbs_pkg::t_pipe_status      o_status
);
    import gbs_pkg::*;

    logic                 r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [AREA_W-1:0]    r_area_a;
    logic [SIZE_W-1:0]    r_ix, r_iy;
    logic [AREA_W-1:0]    r_area_b1, r_area_b2;
    logic [AREA_W-1:0]    r_inter2, r_inter3, r_inter4;
    logic [UNION_W-1:0]   r_union;
    logic [PROD_W-1:0]    r_prod;

    logic [SIZE_W-1:0]    n_ix, n_iy;

    // overlap of [a0, a0+alen) and [b0, b0+blen), clamped at zero
    function automatic logic [SIZE_W-1:0] span(
        input logic signed [COORD_W-1:0] a0,
        input logic [SIZE_W-1:0]         alen,
        input logic signed [COORD_W-1:0] b0,
        input logic [SIZE_W-1:0]         blen
    );
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W:0]   ae, be, hi;
        logic signed [COORD_W+1:0] d;
        lo = (a0 > b0) ? a0 : b0;
        ae = {a0[COORD_W-1], a0} + {2'b00, alen};
        be = {b0[COORD_W-1], b0} + {2'b00, blen};
        hi = (ae < be) ? ae : be;
        d  = {hi[COORD_W], hi} - {{2{lo[COORD_W-1]}}, lo};
        // a positive overlap never exceeds either extent
        return (!d[COORD_W+1] && (d != '0)) ? d[SIZE_W-1:0] : '0;
    endfunction

    always_comb begin
        n_ix = span(i_cur.left, i_cur.width, i_kept.left, i_kept.width);
        n_iy = span(i_cur.top, i_cur.height, i_kept.top, i_kept.height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= i_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        // current box is stable for the whole scan
        r_area_a  <= i_cur.width * i_cur.height;
        // stage 1: spans and kept area
        r_ix      <= n_ix;
        r_iy      <= n_iy;
        r_area_b1 <= i_kept.width * i_kept.height;
        // stage 2: intersection
        r_inter2  <= r_ix * r_iy;
        r_area_b2 <= r_area_b1;
        // stage 3: union
        r_union   <= {1'b0, r_area_a} + {1'b0, r_area_b2} - {1'b0, r_inter2};
        r_inter3  <= r_inter2;
        // stage 4: threshold * union
        r_prod    <= i_thr * r_union;
        r_inter4  <= r_inter3;
    end

    assign o_status.busy = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;
    assign o_status.hit  = r_v4 &&
        ({{(PROD_W-AREA_W-FRAC_W){1'b0}}, r_inter4, {FRAC_W{1'b0}}} > r_prod);

endmodule

// File: hdl/greedy_box_suppression_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// Greedy IoU suppression of score-sorted boxes against a kept-box memory.
// ----------------------------------------------------------------------------
//  port     dir  handshake     carries
//  i_box    in   valid/ready   first_box, box_left, box_top, box_width, box_height
//  o_res    out  valid/ready   keep, box_rank, kept_total, overflow
//  i_cfg    in   valid/ready   overlap_threshold (always ready)
//
//  A box is accepted, the kept boxes of its set are read from the store one by one,
//  the scan is closed and the compare pipeline drains; the box, if kept, is then
//  written back in the same cycle as its result is loaded.
//  Synchronous active-low reset clears control state; the store needs no clear.
//  A waiting result holds the unit in its final step; no new box is taken
//  until that result has been loaded into the output register.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit #(
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gbs_box_if.sink  i_box,
    gbs_res_if.source o_res,
    gbs_cfg_if.sink  i_cfg
);
    import gbs_pkg::*;

    localparam int AW    = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_box                r_cur;
    logic [CNT_W-1:0]    r_idx, r_count, n_count;
    logic [POS_W-1:0]    r_pos;
    logic [RANK_W-1:0]   r_rank;
    logic                r_drop;
    logic [THR_W-1:0]    r_thr;

    logic                r_out_valid;
    logic                r_out_keep;
    logic [RANK_W-1:0]   r_out_rank;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                r_out_ovf;

    logic                in_acc, out_free, finish, issue, room, keep_now;
    logic [POS_W-1:0]    pos_base;
    logic [TOTAL_W-1:0]  total_now;
    t_box                kept_q;
    t_pipe_status        pipe_st;

    assign in_acc   = i_box.valid && i_box.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign finish   = (r_state == S_DONE) && out_free;
    assign issue    = (r_state == S_SCAN) && (r_idx < r_count);
    assign room     = r_count < CNT_W'(MAX_BOXES);
    assign keep_now = !r_drop && room;
    assign n_count  = r_count + CNT_W'(keep_now);
    assign pos_base = i_box.first_box ? '0 : r_pos;

    always_comb begin
        if (32'(n_count) > 32'(TOTAL_MAX)) begin
            total_now = TOTAL_MAX;
        end else begin
            total_now = TOTAL_W'(n_count);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_SCAN;
            S_SCAN:  if (!issue) n_state = S_DRAIN;
            S_DRAIN: if (!pipe_st.busy) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.data;
            end
            if (in_acc) begin
                r_idx  <= '0;
                r_drop <= 1'b0;
                r_pos  <= (pos_base == POS_MAX) ? POS_MAX : pos_base + 1'b1;
                if (i_box.first_box) begin
                    r_count <= '0;
                end
            end else begin
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (pipe_st.hit) begin
                    r_drop <= 1'b1;
                end
            end
            if (finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur.left   <= i_box.box_left;
            r_cur.top    <= i_box.box_top;
            r_cur.width  <= i_box.box_width;
            r_cur.height <= i_box.box_height;
            r_rank       <= (pos_base > POS_W'(RANK_MAX)) ? RANK_MAX : pos_base[RANK_W-1:0];
        end
        if (finish) begin
            r_out_keep  <= keep_now;
            r_out_rank  <= r_rank;
            r_out_total <= total_now;
            r_out_ovf   <= !r_drop && !room;
        end
    end

    gbs_box_store #(
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (finish && keep_now),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_cur),
        .i_rd_en   (issue),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (kept_q)
    );

    gbs_iou_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_cur    (r_cur),
        .i_kept   (kept_q),
        .i_thr    (r_thr),
        .o_status (pipe_st)
    );

    assign i_box.ready      = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_out_valid;
    assign o_res.keep       = r_out_keep;
    assign o_res.box_rank   = r_out_rank;
    assign o_res.kept_total = r_out_total;
    assign o_res.overflow   = r_out_ovf;

endmodule

// File: hdl/gbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for the greedy box suppression unit, bound to the top.
// ----------------------------------------------------------------------------
module gbs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_keep,
    input logic [gbs_pkg::TOTAL_W-1:0]  i_kept_total,
    input logic                         i_overflow
);
    import gbs_pkg::*;

    // a stalled result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_keep)
            && $stable(i_kept_total) && $stable(i_overflow))
        else $error("result item changed while stalled");

    a_keep_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_keep && i_overflow))
        else $error("keep and overflow both set");

    a_keep_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_keep |-> i_kept_total != '0)
        else $error("kept box but kept_total is zero");

    // one box at a time: the scan starts straight after acceptance
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("box input ready while a box is in progress");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_box.valid),
    .i_in_ready   (i_box.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_keep       (o_res.keep),
    .i_kept_total (o_res.kept_total),
    .i_overflow   (o_res.overflow)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_box_suppression_unit. Box sets of clustered
// and random content are streamed under several overlap thresholds, and each
// result item is compared with a bench-side model of greedy IoU suppression.
// ----------------------------------------------------------------------------
module tb;
    import gbs_pkg::*;

    localparam int MAX_BOXES = MAX_BOXES_DEF;
    localparam int DOG_LIMIT = 4000;   // cycles with no handshake on any channel
    localparam int HOLD_LEN  = 400;    // long receiver hold-off
    localparam int SETTLE    = 16;

    typedef struct {
        logic first;
        t_box box;
    } t_box_item;

    typedef struct {
        logic               keep;
        logic [RANK_W-1:0]  rank;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    gbs_box_if box_ch ();
    gbs_res_if res_ch ();
    gbs_cfg_if cfg_ch ();

    greedy_box_suppression_unit #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // model state
    t_box             kept_store [MAX_BOXES];
    int               kept_n    = 0;
    int               set_pos   = 0;
    logic [THR_W-1:0] thr_model = THR_RESET;

    t_box_item box_queue[$];
    t_verdict  verdict_queue[$];
    t_box_item cur_item;
    t_verdict  want_v;

    int items_queued = 0;
    int results_done = 0;
    int mismatches   = 0;
    bit steady       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic int overlap_len(int a0, int alen, int b0, int blen);
        int lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic bit box_suppressed(t_box a, t_box b);
        longint ix, iy, inter, area_a, area_b, uni;
        ix = overlap_len(int'($signed(a.left)), int'(a.width),
                         int'($signed(b.left)), int'(b.width));
        iy = overlap_len(int'($signed(a.top)), int'(a.height),
                         int'($signed(b.top)), int'(b.height));
        inter  = ix * iy;
        area_a = longint'(a.width) * longint'(a.height);
        area_b = longint'(b.width) * longint'(b.height);
        uni    = area_a + area_b - inter;
        return (inter * 1024) > (longint'(thr_model) * uni);
    endfunction

    function automatic t_verdict judge_box(t_box_item it);
        t_verdict v;
        bit       hit;
        int       i;
        hit = 1'b0;
        if (it.first) begin
            kept_n  = 0;
            set_pos = 0;
        end
        v.rank = (set_pos > int'(RANK_MAX)) ? RANK_MAX : RANK_W'(set_pos);
        if (set_pos < int'(POS_MAX))
            set_pos++;
        for (i = 0; i < kept_n; i++) begin
            if (box_suppressed(it.box, kept_store[i]))
                hit = 1'b1;
        end
        v.keep     = 1'b0;
        v.overflow = 1'b0;
        if (!hit) begin
            if (kept_n < MAX_BOXES) begin
                kept_store[kept_n] = it.box;
                kept_n++;
                v.keep = 1'b1;
            end else begin
                v.overflow = 1'b1;
            end
        end
        v.total = TOTAL_W'(kept_n);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths: mostly short, now and then long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------------
    // Box driver
    // ------------------------------------------------------------------------
    int box_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_ch.valid <= 1'b0;
        end else begin
            if (box_ch.valid && box_ch.ready)
                verdict_queue = {verdict_queue, judge_box(cur_item)};
            if (!box_ch.valid || box_ch.ready) begin
                if (box_gap > 0) begin
                    box_gap--;
                    box_ch.valid <= 1'b0;
                end else if (box_queue.size() > 0) begin
                    cur_item = box_queue.pop_front();
                    box_ch.valid      <= 1'b1;
                    box_ch.first_box  <= cur_item.first;
                    box_ch.box_left   <= cur_item.box.left;
                    box_ch.box_top    <= cur_item.box.top;
                    box_ch.box_width  <= cur_item.box.width;
                    box_ch.box_height <= cur_item.box.height;
                    box_gap = pick_gap();
                end else begin
                    box_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready: random stalls plus two long hold-offs
    // ------------------------------------------------------------------------
    int res_stall  = 0;
    int res_seen   = 0;
    int holds_done = 0;
    int res_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                res_seen++;
            if (res_stall > 0) begin
                res_stall--;
                res_ch.ready <= 1'b0;
            end else if ((holds_done == 0 && res_seen >= 40) ||
                         (holds_done == 1 && res_seen >= 1100)) begin
                holds_done++;
                res_stall = HOLD_LEN - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_gap = pick_gap();
                if (res_gap == 0) begin
                    res_ch.ready <= 1'b1;
                end else begin
                    res_stall = res_gap - 1;
                    res_ch.ready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_done++;
            if (verdict_queue.size() == 0) begin
                $display("%0t ns: result item with none expected, keep %0d rank %0d",
                         $time, res_ch.keep, res_ch.box_rank);
                mismatches++;
            end else begin
                want_v = verdict_queue.pop_front();
                check_field("keep", 8'(want_v.keep), 8'(res_ch.keep));
                check_field("box_rank", 8'(want_v.rank), 8'(res_ch.box_rank));
                check_field("kept_total", want_v.total, res_ch.kept_total);
                check_field("overflow", 8'(want_v.overflow), 8'(res_ch.overflow));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    int dog = 0;

    always @(posedge i_clk) begin
        if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            dog = 0;
        else
            dog++;
        if (dog >= DOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, DOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic push_box(input bit first, input int l, input int t,
                            input int w, input int h);
        t_box_item it;
        it.first      = first;
        it.box.left   = COORD_W'(l);
        it.box.top    = COORD_W'(t);
        it.box.width  = SIZE_W'(w);
        it.box.height = SIZE_W'(h);
        box_queue = {box_queue, it};
        items_queued++;
    endtask

    task automatic noise_box(input bit first);
        int w, h;
        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(32767);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(32767);
        push_box(first, int'($urandom_range(65535)) - 32768,
                 int'($urandom_range(65535)) - 32768, w, h);
    endtask

    // boxes scattered round one centre, so overlaps span the whole IoU range
    task automatic cluster_run(input bit opens, input int count);
        int cx, cy, s, j, k;
        s  = ($urandom_range(9) == 0) ? $urandom_range(32767, 4000)
                                      : $urandom_range(4000, 4);
        j  = s / 2 + 1;
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        for (k = 0; k < count; k++) begin
            push_box(opens && k == 0,
                     clamp(cx + int'($urandom_range(j)) - j / 2, -32768, 32767),
                     clamp(cy + int'($urandom_range(j)) - j / 2, -32768, 32767),
                     clamp(s + int'($urandom_range(j)) - j / 2, 0, 32767),
                     clamp(s + int'($urandom_range(j)) - j / 2, 0, 32767));
        end
    endtask

    task automatic random_sets(input int n);
        int left_n, sz, r, k;
        left_n = n;
        while (left_n > 0) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
            if (sz > left_n)
                sz = left_n;
            r = $urandom_range(99);
            if (r < 75) begin
                cluster_run(1'b1, sz);
            end else if (r < 88) begin
                for (k = 0; k < sz; k++)
                    noise_box($urandom_range(7) == 0);
            end else begin
                // set carried on without an opening flag
                cluster_run(1'b0, sz);
            end
            left_n -= sz;
        end
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        thr_model = value;
    endtask

    task automatic drain();
        do @(posedge i_clk); while (results_done < items_queued);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    int k;

    initial begin
        i_rst_n           = 1'b0;
        box_ch.valid      = 1'b0;
        box_ch.first_box  = 1'b0;
        box_ch.box_left   = '0;
        box_ch.box_top    = '0;
        box_ch.box_width  = '0;
        box_ch.box_height = '0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = THR_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, threshold at its reset value; first boxes join the reset set
        push_box(0, 0, 0, 1600, 1600);
        push_box(0, 0, 0, 1600, 1600);                  // identical, dropped
        push_box(0, -32768, -32768, 32767, 32767);
        push_box(0, 32767, 32767, 32767, 32767);
        push_box(0, 100, 100, 0, 500);                  // zero width
        push_box(0, 100, 100, 0, 500);                  // zero union with itself
        push_box(0, 200, 200, 0, 0);
        push_box(0, 1600, 0, 1600, 1600);               // abuts the first box
        push_box(1, 0, 0, 1600, 1600);                  // new set, list emptied
        push_box(1, 0, 0, 100, 100);
        push_box(0, 43, 0, 100, 100);                   // IoU just under 0.4
        push_box(1, 0, 0, 100, 100);
        push_box(0, 42, 0, 100, 100);                   // IoU just over 0.4
        push_box(0, -50, -50, 100, 100);
        push_box(1, -32768, 0, 32767, 16);
        push_box(0, -16, -16, 32767, 32767);
        push_box(0, 0, 0, 32767, 32767);
        drain();

        // zero threshold: any overlap suppresses
        write_threshold('0);
        random_sets(220);
        drain();

        // above 1.0 nothing is suppressed; a set runs past capacity
        write_threshold('1);
        noise_box(1'b1);
        for (k = 1; k < 140; k++)
            noise_box(1'b0);
        random_sets(120);
        drain();

        write_threshold(THR_W'(1024));
        random_sets(220);
        drain();

        // back-to-back stretch with no idling
        steady = 1'b1;
        write_threshold(THR_W'($urandom_range(1023, 1)));
        random_sets(250);
        drain();
        steady = 1'b0;

        write_threshold(THR_W'(1));
        random_sets(200);
        drain();

        // full list at the default threshold, then a dropped box and six spilled ones
        write_threshold(THR_RESET);
        for (k = 0; k < MAX_BOXES; k++)
            push_box(k == 0, k * 64, 0, 48, 48);
        push_box(0, 0, 0, 48, 48);
        for (k = MAX_BOXES; k < MAX_BOXES + 6; k++)
            push_box(0, k * 64, 0, 48, 48);
        random_sets(420);
        drain();

        if (verdict_queue.size() != 0) begin
            $display("%0t ns: %0d expected result items never arrived",
                     $time, verdict_queue.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/gbs_pkg.sv
hdl/gbs_channels.sv
hdl/gbs_box_store.sv
hdl/gbs_iou_pipe.sv
hdl/greedy_box_suppression_unit.sv
hdl/gbs_checker.sv
tb/sv/tb.sv
